FILE: rtl/core/fisr_pkg.sv
// ----------------------------------------------------------------------------
// fisr_pkg
// shared constants and helpers for the pipelined reciprocal square root
// ----------------------------------------------------------------------------
package fisr_pkg;

    localparam logic [31:0] MAGIC_SEED = 32'h5f3759df;
    localparam logic [31:0] FP_HALF    = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] FP_QNAN    = 32'h7fc00000;
    localparam logic [30:0] FP_INF_MAG = 31'h7f800000;

    // stages per arithmetic unit and in the whole pipe
    localparam int UNIT_STAGES = 3;
    localparam int NUM_STAGES  = 5 * UNIT_STAGES;

    // leading zero count of a 48-bit word, 48 when zero
    function automatic logic [5:0] lzc48(input logic [47:0] w);
        logic [5:0] cnt;
        cnt = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (w[i])
            begin
                cnt = 6'(47 - i);
            end
        end
        return cnt;
    endfunction

    // leading zero count of a 28-bit word, 28 when zero
    function automatic logic [4:0] lzc28(input logic [27:0] w);
        logic [4:0] cnt;
        cnt = 5'd28;
        for (int i = 0; i < 28; i++)
        begin
            if (w[i])
            begin
                cnt = 5'(27 - i);
            end
        end
        return cnt;
    endfunction

endpackage

FILE: rtl/core/fisr_fmul.sv
// ----------------------------------------------------------------------------
// fisr_fmul
// three-stage binary32 multiplier, nearest-even, subnormals kept
// ----------------------------------------------------------------------------
module fisr_fmul
(
    input  logic        clk,
    input  logic [2:0]  en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p
);

    // stage a: significand product
    logic [47:0]        prod_reg;
    logic signed [10:0] base_reg;
    logic               sign_a_reg, nan_a_reg, inf_a_reg;

    logic [7:0]  ea8, eb8;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    always_comb
    begin
        ea8    = a[30:23];
        eb8    = b[30:23];
        ma     = {ea8 != 8'd0, a[22:0]};
        mb     = {eb8 != 8'd0, b[22:0]};
        a_nan  = (ea8 == 8'hff) && (a[22:0] != 23'd0);
        b_nan  = (eb8 == 8'hff) && (b[22:0] != 23'd0);
        a_inf  = (ea8 == 8'hff) && (a[22:0] == 23'd0);
        b_inf  = (eb8 == 8'hff) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg   <= ma * mb;
            base_reg   <= $signed(11'((ea8 == 8'd0) ? 8'd1 : ea8))
                        + $signed(11'((eb8 == 8'd0) ? 8'd1 : eb8)) - 11'sd126;
            sign_a_reg <= a[31] ^ b[31];
            nan_a_reg  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
            inf_a_reg  <= a_inf | b_inf;
        end
    end

    // stage b: normalize, or denormalize toward the subnormal range
    logic [47:0]       norm_reg;
    logic              sticky_reg, zero_reg, sign_b_reg, nan_b_reg, inf_b_reg;
    logic signed [10:0] texp_reg;

    logic [5:0]         z;
    logic signed [10:0] diff;
    logic [95:0]        rsh;
    logic [47:0]        norm_next;
    logic               sticky_next;
    logic signed [10:0] texp_next;

    always_comb
    begin
        z           = fisr_pkg::lzc48(prod_reg);
        diff        = base_reg - $signed(11'(z));
        rsh         = {prod_reg, 48'd0} >> 7'(11'sd1 - base_reg);
        sticky_next = 1'b0;
        if (diff >= 11'sd1)
        begin
            texp_next = diff;
            norm_next = prod_reg << z;
        end
        else if (base_reg >= 11'sd1)
        begin
            texp_next = 11'sd1;
            norm_next = prod_reg << 6'(base_reg - 11'sd1);
        end
        else
        begin
            texp_next   = 11'sd1;
            norm_next   = rsh[95:48];
            sticky_next = |rsh[47:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            norm_reg   <= norm_next;
            sticky_reg <= sticky_next;
            texp_reg   <= texp_next;
            zero_reg   <= (prod_reg == 48'd0);
            sign_b_reg <= sign_a_reg;
            nan_b_reg  <= nan_a_reg;
            inf_b_reg  <= inf_a_reg;
        end
    end

    // stage c: round and pack, mantissa carry runs into the exponent
    logic [31:0] p_reg;
    logic [31:0] p_next;
    logic        inc;
    logic [30:0] packed_mag;

    always_comb
    begin
        inc = norm_reg[23] & ((|norm_reg[22:0]) | sticky_reg | norm_reg[24]);
        packed_mag = {texp_reg[7:0] - 8'd1, 23'd0} + 31'(norm_reg[47:24]) + 31'(inc);
        priority if (nan_b_reg)
        begin
            p_next = fisr_pkg::FP_QNAN;
        end
        else if (inf_b_reg || texp_reg >= 11'sd255)
        begin
            p_next = {sign_b_reg, fisr_pkg::FP_INF_MAG};
        end
        else if (zero_reg)
        begin
            p_next = {sign_b_reg, 31'd0};
        end
        else
        begin
            p_next = {sign_b_reg, packed_mag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/fisr_fadd.sv
// ----------------------------------------------------------------------------
// fisr_fadd
// three-stage binary32 adder, nearest-even, subnormals kept
// ----------------------------------------------------------------------------
module fisr_fadd
(
    input  logic        clk,
    input  logic [2:0]  en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] s
);

    // stage a: order by magnitude and align the smaller operand
    logic [26:0] mx_reg, al_reg;
    logic [7:0]  eb_reg;
    logic        sign_a_reg, sub_a_reg, nan_a_reg, inf_a_reg, zsign_a_reg;

    logic [31:0] big, sml;
    logic [7:0]  e_big, e_sml, align_dist;
    logic [23:0] m_big, m_sml;
    logic [49:0] sh;
    logic        a_nan, b_nan, a_inf, b_inf;

    always_comb
    begin
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        m_big = {big[30:23] != 8'd0, big[22:0]};
        m_sml = {sml[30:23] != 8'd0, sml[22:0]};
        align_dist = e_big - e_sml;
        sh    = {m_sml, 26'd0} >> align_dist;
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mx_reg      <= {m_big, 3'd0};
            al_reg      <= {sh[49:24], sh[23] | (|sh[22:0])};
            eb_reg      <= e_big;
            sign_a_reg  <= big[31];
            sub_a_reg   <= a[31] ^ b[31];
            nan_a_reg   <= a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
            inf_a_reg   <= a_inf | b_inf;
            zsign_a_reg <= a[31] & b[31];
        end
    end

    // stage b: add or subtract, find the normalizing shift
    logic [27:0]        sum_reg;
    logic               rsh_reg, zero_reg, sign_b_reg, nan_b_reg, inf_b_reg, zsign_b_reg;
    logic [4:0]         lsh_reg;
    logic signed [9:0]  texp_reg;

    logic [27:0]       sum;
    logic [4:0]        z;
    logic signed [9:0] diff;
    logic [4:0]        lsh_next;
    logic signed [9:0] texp_next;

    always_comb
    begin
        sum  = sub_a_reg ? ({1'b0, mx_reg} - {1'b0, al_reg})
                         : ({1'b0, mx_reg} + {1'b0, al_reg});
        z    = fisr_pkg::lzc28(sum) - 5'd1;
        diff = $signed(10'(eb_reg)) - $signed(10'(z));
        lsh_next = 5'd0;
        if (sum[27])
        begin
            texp_next = $signed(10'(eb_reg)) + 10'sd1;
        end
        else if (diff >= 10'sd1)
        begin
            texp_next = diff;
            lsh_next  = z;
        end
        else
        begin
            texp_next = 10'sd1;
            lsh_next  = 5'(eb_reg - 8'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sum_reg     <= sum;
            rsh_reg     <= sum[27];
            lsh_reg     <= lsh_next;
            texp_reg    <= texp_next;
            zero_reg    <= (sum == 28'd0);
            sign_b_reg  <= sign_a_reg;
            nan_b_reg   <= nan_a_reg;
            inf_b_reg   <= inf_a_reg;
            zsign_b_reg <= zsign_a_reg;
        end
    end

    // stage c: shift, round and pack
    logic [31:0] s_reg;
    logic [31:0] s_next;
    logic [26:0] norm;
    logic        sticky, inc;
    logic [30:0] packed_mag;

    always_comb
    begin
        norm   = rsh_reg ? sum_reg[27:1] : (sum_reg[26:0] << lsh_reg);
        sticky = rsh_reg & sum_reg[0];
        inc    = norm[2] & (norm[1] | norm[0] | sticky | norm[3]);
        packed_mag = {texp_reg[7:0] - 8'd1, 23'd0} + 31'(norm[26:3]) + 31'(inc);
        priority if (nan_b_reg)
        begin
            s_next = fisr_pkg::FP_QNAN;
        end
        else if (inf_b_reg || texp_reg >= 10'sd255)
        begin
            s_next = {sign_b_reg, fisr_pkg::FP_INF_MAG};
        end
        else if (zero_reg)
        begin
            s_next = {zsign_b_reg, 31'd0};
        end
        else
        begin
            s_next = {sign_b_reg, packed_mag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s_reg <= s_next;
        end
    end

    assign s = s_reg;

endmodule

FILE: rtl/core/fast_inverse_square_root.sv
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// bit-trick seed plus one newton step, fully pipelined binary32
// ----------------------------------------------------------------------------
// channel   | handshake            | payload
// input     | in_valid / in_ready  | operand_bits[31:0]
// output    | out_valid / out_ready| result_bits[31:0]
//
// one transaction per cycle sustained while out_ready holds high
// pipe: half*num, *x, *x, 1.5-t, x*u; three registered stages per unit
// each stage advances when empty or when the stage after it advances,
// so bubbles collapse and a stall at the output loses nothing
// reset clears only the stage valid bits
// ----------------------------------------------------------------------------
module fast_inverse_square_root
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_bits
);

    localparam int NS = fisr_pkg::NUM_STAGES;
    localparam int US = fisr_pkg::UNIT_STAGES;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = ~v_reg[i] | en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // seed from the integer view of the operand
    logic [31:0] guess;
    assign guess = fisr_pkg::MAGIC_SEED - {operand_bits[31], operand_bits[31:1]};

    // seed delay line so x meets each unit that needs it
    logic [31:0] x_reg [4*US];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4 * US; k++)
        begin
            if (en[k])
            begin
                x_reg[k] <= (k == 0) ? guess : x_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    logic [31:0] half_num, t1, t2, u;

    fisr_fmul u_mul_half
    (
        .clk (clk),
        .en  (en[US-1:0]),
        .a   (operand_bits),
        .b   (fisr_pkg::FP_HALF),
        .p   (half_num)
    );

    fisr_fmul u_mul_t1
    (
        .clk (clk),
        .en  (en[2*US-1:US]),
        .a   (half_num),
        .b   (x_reg[US-1]),
        .p   (t1)
    );

    fisr_fmul u_mul_t2
    (
        .clk (clk),
        .en  (en[3*US-1:2*US]),
        .a   (t1),
        .b   (x_reg[2*US-1]),
        .p   (t2)
    );

    // 1.5 - t as an add with the sign of t flipped
    fisr_fadd u_sub
    (
        .clk (clk),
        .en  (en[4*US-1:3*US]),
        .a   (fisr_pkg::FP_THREE_HALVES),
        .b   ({~t2[31], t2[30:0]}),
        .s   (u)
    );

    fisr_fmul u_mul_out
    (
        .clk (clk),
        .en  (en[5*US-1:4*US]),
        .a   (x_reg[4*US-1]),
        .b   (u),
        .p   (result_bits)
    );

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    // an empty first stage always takes a transaction
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("input stalled with empty first stage");

    // an accepted transaction lands in the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[0])
        else $error("accepted transaction lost at entry");

    // a stalled result holds its value
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_bits)))
        else $error("stalled result changed");

    // a full pipe with a stalled output refuses new input
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !out_ready) |-> !in_ready)
        else $error("full pipe took a transaction");

endmodule

FILE: tb/sv/fast_inverse_square_root_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_inverse_square_root_tb
// checks the pipelined reciprocal square root against a binary32 predictor
// directed corner operands, then random ones, with random idling on both
// channels; results are compared in order against a queue of expected words
// ----------------------------------------------------------------------------
module fast_inverse_square_root_tb;

    localparam int N_RANDOM  = 800;
    localparam int WD_LIMIT  = 4000;
    localparam int MAX_SHOWN = 10;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] operand_bits;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result_bits;

    logic [31:0] operand_q[$];
    logic [31:0] rsqrt_q[$];
    logic        in_taken;
    int          mismatches;
    int          idle_cycles;

    fast_inverse_square_root i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operand_bits (operand_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_bits  (result_bits)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // binary32 pattern to an exact double
    function automatic real sp_to_real(input logic [31:0] b);
        logic        s;
        int          e;
        logic [23:0] m;
        logic [63:0] d;
        s = b[31];
        e = int'(b[30:23]);
        m = {1'b0, b[22:0]};
        if (e == 255)
        begin
            d = (m == 0) ? {s, 11'h7ff, 52'h0} : {s, 11'h7ff, 1'b1, 51'h0};
        end
        else if (e == 0 && m == 0)
        begin
            d = {s, 63'h0};
        end
        else
        begin
            if (e == 0)
            begin
                e = 1;
                while (!m[23])
                begin
                    m = m << 1;
                    e--;
                end
            end
            d = {s, 11'(e - 127 + 1023), m[22:0], 29'h0};
        end
        return $bitstoreal(d);
    endfunction

    // round a double to binary32, nearest-even, subnormals kept;
    // double rounding after an exact or 53-bit op is innocuous here
    function automatic logic [31:0] real_to_sp(input real v);
        logic [63:0] d;
        logic        s;
        int          ex;
        int          fe;
        int          sh;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        d  = $realtobits(v);
        s  = d[63];
        ex = int'(d[62:52]);
        if (ex == 2047)
        begin
            return (d[51:0] != 0) ? fisr_pkg::FP_QNAN : {s, fisr_pkg::FP_INF_MAG};
        end
        if (ex == 0)
        begin
            return {s, 31'h0};
        end
        sig = {11'h0, 1'b1, d[51:0]};
        fe  = ex - 1023 + 127;
        sh  = (fe >= 1) ? 29 : 30 - fe;
        if (sh >= 55)
        begin
            return {s, 31'h0};
        end
        q    = sig >> sh;
        rem  = sig & ((64'h1 << sh) - 64'h1);
        half = 64'h1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 64'h1;
        end
        mag = (fe >= 1) ? ((64'(fe - 1) << 23) + q) : q;
        if (mag >= 64'h7f800000)
        begin
            return {s, fisr_pkg::FP_INF_MAG};
        end
        return {s, mag[30:0]};
    endfunction

    function automatic logic [31:0] rsqrt_expected(input logic [31:0] op);
        logic [31:0] guess;
        logic [31:0] h;
        logic [31:0] t;
        logic [31:0] u;
        real         x;
        guess = fisr_pkg::MAGIC_SEED - {op[31], op[31:1]};
        x = sp_to_real(guess);
        h = real_to_sp(sp_to_real(fisr_pkg::FP_HALF) * sp_to_real(op));
        t = real_to_sp(sp_to_real(h) * x);
        t = real_to_sp(sp_to_real(t) * x);
        u = real_to_sp(sp_to_real(fisr_pkg::FP_THREE_HALVES) - sp_to_real(t));
        return real_to_sp(x * sp_to_real(u));
    endfunction

    // no idling while the middle of the random run is sent
    function automatic logic pause_now();
        if (operand_q.size() > 300 && operand_q.size() < 500)
        begin
            return 1'b0;
        end
        return $urandom_range(99) < 27;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !pause_now();
            if (!in_valid || in_taken)
            begin
                if (operand_q.size() > 0 && !pause_now())
                begin
                    in_valid     <= 1'b1;
                    operand_bits <= operand_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic [31:0] want;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                rsqrt_q.push_back(rsqrt_expected(operand_bits));
            end
            if (out_valid && out_ready)
            begin
                if (rsqrt_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("unexpected transaction: result_bits %08h", result_bits);
                    end
                end
                else
                begin
                    want = rsqrt_q.pop_front();
                    if (result_bits !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                        begin
                            $display("result_bits mismatch: expected %08h actual %08h",
                                     want, result_bits);
                        end
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= WD_LIMIT)
            begin
                $display("FAIL fast_inverse_square_root");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [31:0] v;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        operand_bits = 32'h0;
        in_taken     = 1'b0;
        mismatches   = 0;
        idle_cycles  = 0;

        // zeros, infinities, nans, subnormals, normal extremes and ordinary values
        operand_q = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
                      32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001,
                      32'h00000002, 32'h007fffff, 32'h00800000, 32'h3f800000,
                      32'h40800000, 32'h7f7fffff, 32'hbf800000, 32'h5f3759df,
                      32'h3e800000, 32'h80000001, 32'haaaaaaaa, 32'h55555555,
                      32'hff7fffff, 32'h41c80000, 32'h3a83126f};
        for (int i = 0; i < N_RANDOM; i++)
        begin
            v = $urandom();
            // mostly positive values of moderate magnitude
            if ($urandom_range(99) < 60)
            begin
                v[31]    = 1'b0;
                v[30:23] = 8'($urandom_range(200, 40));
            end
            operand_q.push_back(v);
        end

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        wait (operand_q.size() == 0);
        @(posedge clk);
        while (in_valid || rsqrt_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (fisr_pkg::NUM_STAGES + 20) @(posedge clk);
        if (mismatches == 0 && rsqrt_q.size() == 0)
        begin
            $display("PASS fast_inverse_square_root");
        end
        else
        begin
            $display("FAIL fast_inverse_square_root");
        end
        $finish;
    end

endmodule

FILE: fast_inverse_square_root.f
rtl/core/fisr_pkg.sv
rtl/core/fisr_fmul.sv
rtl/core/fisr_fadd.sv
rtl/core/fast_inverse_square_root.sv
tb/sv/fast_inverse_square_root_tb.sv
